FILE: design/pidsr_pkg.sv
// constants for the pid position to step rate core
// widths, register codes, reset values and fixed-point constants
// no dependencies
package pidsr_pkg;

    localparam int GAIN_W         = 24;
    localparam int LIM_W          = 10;
    localparam int INT_W          = LIM_W + 1;
    localparam int PSC_W          = 16;
    localparam int PID_W          = 32;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int X_W            = GAIN_FRAC_BITS;
    localparam int CNT_W          = $clog2(GAIN_W);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = GAIN_W;
    localparam int OUT_DATA_W  = ((3 + PSC_W + PID_W + 7) / 8) * 8;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_KP       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KI       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KD       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PSC_MIN  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PSC_MAX  = 3'd7;

    localparam logic [GAIN_W-1:0] KP_RESET       = 24'd100663;
    localparam logic [GAIN_W-1:0] KI_RESET       = 24'd168;
    localparam logic [GAIN_W-1:0] KD_RESET       = 24'd33554;
    localparam logic [LIM_W-1:0]  DEADBAND_RESET = 10'd5;
    localparam logic [LIM_W-1:0]  WINDOW_RESET   = 10'd100;
    localparam logic [LIM_W-1:0]  LIMIT_RESET    = 10'd250;
    localparam logic [PSC_W-1:0]  PSC_MIN_RESET  = 16'd100;
    localparam logic [PSC_W-1:0]  PSC_MAX_RESET  = 16'd1000;

    // speed scale: one, minimum speed 0.05 rounded, and the span between them
    localparam longint unsigned Q_ONE_L  = 64'd1 << GAIN_FRAC_BITS;
    localparam longint unsigned Q_SMIN_L = (Q_ONE_L + 64'd10) / 64'd20;

    localparam logic [PID_W-1:0] Q_ONE       = PID_W'(Q_ONE_L);
    localparam logic [PID_W-1:0] Q_SPEED_MIN = PID_W'(Q_SMIN_L);
    localparam logic [X_W-1:0]   Q_SPAN      = X_W'(Q_ONE_L - Q_SMIN_L);

endpackage

FILE: design/pid_position_to_step_rate_core.sv
// one-axis incremental pid with clamped integral, turning a position error
// into run, start, direction, step prescaler and the saturated pid value
// depends on pidsr_pkg
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: target, measured position
// m_        out  m_tvalid/m_tready    m_tdata: run, start, direction, prescaler, pid
// cfg_      in   cfg_write            cfg_index, cfg_data
//
// a word outside the deadband is evaluated, multiplied bit-serially by the gains
// (one gain bit per cycle), saturated, clamped to a speed, put through the serial
// speed*span product and the restoring divide by the speed span and limited to
// the prescaler range; a word inside the deadband goes from evaluation straight
// to the output. the next word is taken once the result sits in the output
// register; a stalled m_tready holds the core in its final step.
// reset restores the default gains and limits and clears the pid history.
module pid_position_to_step_rate_core #(
    parameter int POSITION_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // [POSITION_BITS-1:0] target_position, [2*POSITION_BITS-1:POSITION_BITS]
    // measured_position, zero padded to bytes
    input  logic [((2*POSITION_BITS+7)/8)*8-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // [0] run, [1] start_pulse, [2] direction, [18:3] prescaler, [50:19] pid_value
    output logic [pidsr_pkg::OUT_DATA_W-1:0] m_tdata,

    input  logic cfg_write,
    input  logic [pidsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pidsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int E_W  = POSITION_BITS + 1;
    localparam int D_W  = E_W + 2;
    localparam int T_W  = (D_W > pidsr_pkg::INT_W) ? D_W : pidsr_pkg::INT_W;
    localparam int A_W  = T_W + 3;
    localparam int S_W  = ((E_W > pidsr_pkg::INT_W) ? E_W : pidsr_pkg::INT_W) + 1;
    localparam int C_W  = (POSITION_BITS > pidsr_pkg::LIM_W) ? POSITION_BITS
                                                               : pidsr_pkg::LIM_W;
    localparam int GW   = pidsr_pkg::GAIN_W;
    localparam int PW   = pidsr_pkg::PSC_W;
    localparam int QW   = pidsr_pkg::PID_W;
    localparam int XW   = pidsr_pkg::X_W;
    localparam int LW   = pidsr_pkg::LIM_W;
    localparam int IW   = pidsr_pkg::INT_W;
    localparam int NW   = pidsr_pkg::CNT_W;
    localparam int OW   = pidsr_pkg::OUT_DATA_W;
    localparam int PADW = OW - 3 - PW - QW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EVAL  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_SAT   = 4'd3;
    localparam logic [3:0] ST_SPEED = 4'd4;
    localparam logic [3:0] ST_PMUL  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_PSC   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic [NW-1:0] MUL_LAST = NW'(GW - 1);
    localparam logic [NW-1:0] PSC_LAST = NW'(PW - 1);

    // configuration
    logic [GW-1:0] kp_reg, ki_reg, kd_reg;
    logic [LW-1:0] deadband_reg, window_reg, limit_reg;
    logic [PW-1:0] pmin_reg, pmax_reg;

    // control and pid history
    logic [3:0]             state_reg, state_next;
    logic [NW-1:0]          cnt_reg, cnt_next;
    logic                   running_reg, running_next;
    logic signed [E_W-1:0]  err1_reg, err1_next;
    logic signed [E_W-1:0]  err2_reg, err2_next;
    logic signed [IW-1:0]   integ_reg, integ_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic signed [E_W-1:0]  e_reg, e_next;
    logic signed [IW-1:0]   isum_reg, isum_next;
    logic signed [D_W-1:0]  d2_reg, d2_next;
    logic [GW-1:0]          kp_sh_reg, kp_sh_next;
    logic [GW-1:0]          ki_sh_reg, ki_sh_next;
    logic [GW-1:0]          kd_sh_reg, kd_sh_next;
    logic signed [A_W-1:0]  acc_reg, acc_next;
    logic [GW-1:0]          lo_reg, lo_next;
    logic [QW-1:0]          pid_reg, pid_next;
    logic [XW-1:0]          x_reg, x_next;
    logic [PW-1:0]          span_sh_reg, span_sh_next;
    logic                   span_neg_reg, span_neg_next;
    logic [XW-1:0]          pacc_reg, pacc_next;
    logic [PW-1:0]          plo_reg, plo_next;
    logic                   run_res_reg, run_res_next;
    logic                   start_res_reg, start_res_next;
    logic [PW-1:0]          psc_res_reg, psc_res_next;
    logic [OW-1:0]          out_data_reg, out_data_next;

    // error evaluation
    logic [POSITION_BITS-1:0] ae;
    logic                     in_stop, in_win;
    logic signed [S_W-1:0]    isum_sum, isum_raw, lim_s, isum_clamp;
    logic signed [D_W-1:0]    d2_new;

    // serial gain multiply
    logic signed [A_W-1:0]  mul_term, mul_sum;

    // saturation and speed
    logic [A_W-QW+GW:0]     sat_hi;
    logic                   sat_ok;
    logic [QW-1:0]          pid_sat, mag;
    logic signed [PW:0]     span;

    // speed product, divide and prescaler limit
    logic [XW:0]            pmul_sum, div_t;
    logic                   div_ge;
    logic signed [PW+1:0]   term, psc_raw, pmin_s, pmax_s;
    logic                   load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- error, integral and second difference
    assign ae = e_reg[E_W-1] ? POSITION_BITS'(-e_reg) : POSITION_BITS'(e_reg);
    assign in_stop = C_W'(ae) <= C_W'(deadband_reg);
    assign in_win  = C_W'(ae) <  C_W'(window_reg);

    assign isum_sum = S_W'(integ_reg) + S_W'(e_reg);
    assign isum_raw = in_win ? isum_sum : '0;
    assign lim_s    = S_W'($signed({1'b0, limit_reg}));
    assign isum_clamp = (isum_raw > lim_s)  ? lim_s :
                        (isum_raw < -lim_s) ? -lim_s : isum_raw;

    assign d2_new = D_W'(e_reg) - (D_W'(err1_reg) <<< 1) + D_W'(err2_reg);

    // ---------------- one gain bit per cycle, lsb first
    assign mul_term = (kp_sh_reg[0] ? A_W'(e_reg)    : A_W'(0))
                    + (ki_sh_reg[0] ? A_W'(isum_reg) : A_W'(0))
                    + (kd_sh_reg[0] ? A_W'(d2_reg)   : A_W'(0));
    assign mul_sum = acc_reg + mul_term;

    // ---------------- saturate the product sum to 32 bits
    assign sat_hi  = acc_reg[A_W-1:QW-GW-1];
    assign sat_ok  = (&sat_hi) | ~(|sat_hi);
    assign pid_sat = sat_ok ? {acc_reg[QW-GW-1:0], lo_reg} :
                     acc_reg[A_W-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};

    assign mag  = pid_reg[QW-1] ? (~pid_reg + 1'b1) : pid_reg;
    assign span = $signed({1'b0, pmax_reg}) - $signed({1'b0, pmin_reg});

    // ---------------- speed * |span|, then restoring divide by the speed span
    assign pmul_sum = {1'b0, pacc_reg} + (span_sh_reg[0] ? {1'b0, x_reg} : '0);
    assign div_t    = {pacc_reg, plo_reg[PW-1]};
    assign div_ge   = div_t >= {1'b0, pidsr_pkg::Q_SPAN};

    assign term    = span_neg_reg ? -$signed({2'b00, plo_reg}) : $signed({2'b00, plo_reg});
    assign pmin_s  = $signed({2'b00, pmin_reg});
    assign pmax_s  = $signed({2'b00, pmax_reg});
    assign psc_raw = pmax_s - term;

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        running_next   = running_reg;
        err1_next      = err1_reg;
        err2_next      = err2_reg;
        integ_next     = integ_reg;
        e_next         = e_reg;
        isum_next      = isum_reg;
        d2_next        = d2_reg;
        kp_sh_next     = kp_sh_reg;
        ki_sh_next     = ki_sh_reg;
        kd_sh_next     = kd_sh_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        pid_next       = pid_reg;
        x_next         = x_reg;
        span_sh_next   = span_sh_reg;
        span_neg_next  = span_neg_reg;
        pacc_next      = pacc_reg;
        plo_next       = plo_reg;
        run_res_next   = run_res_reg;
        start_res_next = start_res_reg;
        psc_res_next   = psc_res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    e_next = $signed({1'b0, s_tdata[POSITION_BITS-1:0]})
                           - $signed({1'b0, s_tdata[2*POSITION_BITS-1:POSITION_BITS]});
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (in_stop)
                begin
                    // inside the deadband: history kept, all result fields zero
                    running_next   = 1'b0;
                    run_res_next   = 1'b0;
                    start_res_next = 1'b0;
                    psc_res_next   = '0;
                    pid_next       = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    integ_next     = IW'(isum_clamp);
                    isum_next      = IW'(isum_clamp);
                    d2_next        = d2_new;
                    err2_next      = err1_reg;
                    err1_next      = e_reg;
                    start_res_next = ~running_reg;
                    run_res_next   = 1'b1;
                    running_next   = 1'b1;
                    kp_sh_next     = kp_reg;
                    ki_sh_next     = ki_reg;
                    kd_sh_next     = kd_reg;
                    acc_next       = '0;
                    cnt_next       = '0;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next   = mul_sum >>> 1;
                lo_next    = {mul_sum[0], lo_reg[GW-1:1]};
                kp_sh_next = kp_sh_reg >> 1;
                ki_sh_next = ki_sh_reg >> 1;
                kd_sh_next = kd_sh_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                pid_next   = pid_sat;
                state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                // clamp |pid| to [min speed, one] and offset by min speed
                if (mag >= pidsr_pkg::Q_ONE)
                begin
                    x_next = pidsr_pkg::Q_SPAN;
                end
                else if (mag < pidsr_pkg::Q_SPEED_MIN)
                begin
                    x_next = '0;
                end
                else
                begin
                    x_next = XW'(mag - pidsr_pkg::Q_SPEED_MIN);
                end
                span_neg_next = span[PW];
                span_sh_next  = span[PW] ? PW'(-span) : PW'(span);
                pacc_next     = '0;
                cnt_next      = '0;
                state_next    = ST_PMUL;
            end
            ST_PMUL:
            begin
                pacc_next    = pmul_sum[XW:1];
                plo_next     = {pmul_sum[0], plo_reg[PW-1:1]};
                span_sh_next = span_sh_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == PSC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // remainder stays below the divisor, quotient shifts in at the bottom
                pacc_next = div_ge ? XW'(div_t - {1'b0, pidsr_pkg::Q_SPAN}) : XW'(div_t);
                plo_next  = {plo_reg[PW-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == PSC_LAST)
                begin
                    state_next = ST_PSC;
                end
            end
            ST_PSC:
            begin
                if (psc_raw > pmax_s)
                begin
                    psc_res_next = pmax_reg;
                end
                else if (psc_raw < pmin_s)
                begin
                    psc_res_next = pmin_reg;
                end
                else
                begin
                    psc_res_next = PW'(psc_raw);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{PADW{1'b0}}, pid_reg, psc_res_reg,
                              ~pid_reg[QW-1] & (|pid_reg), start_res_reg, run_res_reg};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= pidsr_pkg::KP_RESET;
            ki_reg       <= pidsr_pkg::KI_RESET;
            kd_reg       <= pidsr_pkg::KD_RESET;
            deadband_reg <= pidsr_pkg::DEADBAND_RESET;
            window_reg   <= pidsr_pkg::WINDOW_RESET;
            limit_reg    <= pidsr_pkg::LIMIT_RESET;
            pmin_reg     <= pidsr_pkg::PSC_MIN_RESET;
            pmax_reg     <= pidsr_pkg::PSC_MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pidsr_pkg::REG_KP:       kp_reg       <= cfg_data[GW-1:0];
                pidsr_pkg::REG_KI:       ki_reg       <= cfg_data[GW-1:0];
                pidsr_pkg::REG_KD:       kd_reg       <= cfg_data[GW-1:0];
                pidsr_pkg::REG_DEADBAND: deadband_reg <= cfg_data[LW-1:0];
                pidsr_pkg::REG_WINDOW:   window_reg   <= cfg_data[LW-1:0];
                pidsr_pkg::REG_LIMIT:    limit_reg    <= cfg_data[LW-1:0];
                pidsr_pkg::REG_PSC_MIN:  pmin_reg     <= cfg_data[PW-1:0];
                pidsr_pkg::REG_PSC_MAX:  pmax_reg     <= cfg_data[PW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            running_reg   <= 1'b0;
            err1_reg      <= '0;
            err2_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            running_reg   <= running_next;
            err1_reg      <= err1_next;
            err2_reg      <= err2_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg         <= e_next;
        isum_reg      <= isum_next;
        d2_reg        <= d2_next;
        kp_sh_reg     <= kp_sh_next;
        ki_sh_reg     <= ki_sh_next;
        kd_sh_reg     <= kd_sh_next;
        acc_reg       <= acc_next;
        lo_reg        <= lo_next;
        pid_reg       <= pid_next;
        x_reg         <= x_next;
        span_sh_reg   <= span_sh_next;
        span_neg_reg  <= span_neg_next;
        pacc_reg      <= pacc_next;
        plo_reg       <= plo_next;
        run_res_reg   <= run_res_next;
        start_res_reg <= start_res_next;
        psc_res_reg   <= psc_res_next;
        out_data_reg  <= out_data_next;
    end

endmodule

FILE: verif/pidsr_step_checker.sv
`timescale 1ns / 100ps
// checker for the pid position to step rate core: predicts each drive command
// from the accepted position words and compares the output words field by field
// depends on pidsr_pkg for the register codes and the port widths
module pidsr_step_checker #(
    parameter int POSITION_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    input  logic s_tready,
    // [POSITION_BITS-1:0] target_position, [2*POSITION_BITS-1:POSITION_BITS]
    // measured_position, zero padded to bytes
    input  logic [((2*POSITION_BITS+7)/8)*8-1:0] s_tdata,

    input  logic m_tvalid,
    input  logic m_tready,
    // [0] run, [1] start_pulse, [2] direction, [18:3] prescaler, [50:19] pid_value
    input  logic [pidsr_pkg::OUT_DATA_W-1:0] m_tdata,

    input  logic cfg_write,
    input  logic [pidsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pidsr_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int results_seen,
    output int fail_count,
    output int stopped_seen,
    output int starts_seen,
    output int saturated_seen
);

    localparam longint       SPEED_ONE   = 64'sd1 << 24;
    localparam longint       SPEED_FLOOR = (SPEED_ONE + 10) / 20;
    localparam longint       PID_TOP     = 64'sd2147483647;
    localparam longint       PID_BOTTOM  = -64'sd2147483648;

    typedef struct {
        bit        run;
        bit        start;
        bit        dir;
        bit [15:0] psc;
        int        pid;
    } drive_cmd_t;

    // gains and limits as the core holds them
    logic [23:0] gain_p, gain_i, gain_d;
    logic [9:0]  stop_band, int_window, int_limit;
    logic [15:0] psc_fast, psc_slow;

    // controller history
    logic signed [10:0] err_last, err_before, integ_acc;
    logic               drive_on;

    drive_cmd_t drive_cmds[$];
    drive_cmd_t want;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint exp_val);
        if (got != exp_val)
            report($sformatf("result %0d %s = %0d, expected %0d",
                             results_seen, name, got, exp_val));
    endtask

    function automatic bit [15:0] speed_to_prescaler(input longint pid);
        longint speed, span, term, psc, pmin, pmax;
        speed = (pid < 0) ? -pid : pid;
        pmin  = psc_fast;
        pmax  = psc_slow;
        span  = pmax - pmin;
        if (speed > SPEED_ONE)
            speed = SPEED_ONE;
        if (speed < SPEED_FLOOR)
            speed = SPEED_FLOOR;
        // signed division truncates toward zero
        term = ((speed - SPEED_FLOOR) * span) / (SPEED_ONE - SPEED_FLOOR);
        psc  = pmax - term;
        if (psc > pmax)
            psc = pmax;
        else if (psc < pmin)
            psc = pmin;
        return psc[15:0];
    endfunction

    function automatic drive_cmd_t next_command(input logic [POSITION_BITS-1:0] tgt,
                                                input logic [POSITION_BITS-1:0] meas);
        drive_cmd_t cmd;
        int         t, m, e, ae, isum, lim, d2, band, win;
        longint     kpv, kiv, kdv, acc;
        t    = tgt;
        m    = meas;
        lim  = int_limit;
        band = stop_band;
        win  = int_window;
        kpv  = gain_p;
        kiv  = gain_i;
        kdv  = gain_d;
        e    = t - m;
        ae   = (e < 0) ? -e : e;
        cmd  = '{run: 1'b0, start: 1'b0, dir: 1'b0, psc: 16'd0, pid: 0};
        if (ae <= band)
        begin
            drive_on = 1'b0;
            stopped_seen++;
            return cmd;
        end
        isum = (ae < win) ? int'(integ_acc) + e : 0;
        if (isum > lim)
            isum = lim;
        if (isum < -lim)
            isum = -lim;
        integ_acc = isum;
        d2  = e - 2 * int'(err_last) + int'(err_before);
        acc = kpv * e + kiv * isum + kdv * d2;
        if (acc > PID_TOP || acc < PID_BOTTOM)
            saturated_seen++;
        if (acc > PID_TOP)
            acc = PID_TOP;
        if (acc < PID_BOTTOM)
            acc = PID_BOTTOM;
        err_before = err_last;
        err_last   = e;
        cmd.run    = 1'b1;
        cmd.start  = !drive_on;
        cmd.dir    = acc > 0;
        cmd.psc    = speed_to_prescaler(acc);
        cmd.pid    = int'(acc);
        if (!drive_on)
            starts_seen++;
        drive_on = 1'b1;
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p     = 24'd100663;
            gain_i     = 24'd168;
            gain_d     = 24'd33554;
            stop_band  = 10'd5;
            int_window = 10'd100;
            int_limit  = 10'd250;
            psc_fast   = 16'd100;
            psc_slow   = 16'd1000;
            err_last   = '0;
            err_before = '0;
            integ_acc  = '0;
            drive_on   = 1'b0;
            drive_cmds.delete();
            results_seen <= 0;
        end
        else
        begin
            // the older word leaves before a new one is predicted
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (drive_cmds.size() == 0)
                begin
                    report($sformatf("result %0d arrived with nothing pending", results_seen));
                end
                else
                begin
                    want = drive_cmds.pop_front();
                    check_field("run", m_tdata[0], want.run);
                    check_field("start_pulse", m_tdata[1], want.start);
                    check_field("direction", m_tdata[2], want.dir);
                    check_field("prescaler", m_tdata[18:3], want.psc);
                    check_field("pid_value", $signed(m_tdata[50:19]), want.pid);
                end
            end
            if (s_tvalid && s_tready)
                drive_cmds.push_back(next_command(s_tdata[POSITION_BITS-1:0],
                                                  s_tdata[2*POSITION_BITS-1:POSITION_BITS]));
            if (cfg_write)
            begin
                case (cfg_index)
                    pidsr_pkg::REG_KP:       gain_p     = cfg_data[23:0];
                    pidsr_pkg::REG_KI:       gain_i     = cfg_data[23:0];
                    pidsr_pkg::REG_KD:       gain_d     = cfg_data[23:0];
                    pidsr_pkg::REG_DEADBAND: stop_band  = cfg_data[9:0];
                    pidsr_pkg::REG_WINDOW:   int_window = cfg_data[9:0];
                    pidsr_pkg::REG_LIMIT:    int_limit  = cfg_data[9:0];
                    pidsr_pkg::REG_PSC_MIN:  psc_fast   = cfg_data[15:0];
                    pidsr_pkg::REG_PSC_MAX:  psc_slow   = cfg_data[15:0];
                    default:      ;
                endcase
            end
        end
    end

endmodule

FILE: verif/pid_position_to_step_rate_core_test.sv
`timescale 1ns / 100ps
// testbench top for the pid position to step rate core: drives position words
// in bursts under several gain settings and gives the verdict
// depends on pidsr_pkg, pid_position_to_step_rate_core and pidsr_step_checker
module pid_position_to_step_rate_core_test;

    localparam int POS_W          = 10;
    localparam int IN_W           = ((2 * POS_W + 7) / 8) * 8;
    localparam int POS_TOP        = (1 << POS_W) - 1;
    localparam int N_PHASES       = 10;
    localparam int WORDS_PER_SET  = 150;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 80;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;

    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [pidsr_pkg::OUT_DATA_W-1:0] m_tdata;

    logic                              cfg_write = 1'b0;
    logic [pidsr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pidsr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int results_seen, fail_count, stopped_seen, starts_seen, saturated_seen;
    int words_sent   = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    int cur_deadband = 5;

    // receiver stall pattern state
    int ready_mode  = 0;
    int mode_left   = 0;
    int stall_left  = 0;

    always #6 clk = ~clk;

    pid_position_to_step_rate_core #(
        .POSITION_BITS(POS_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pidsr_step_checker #(
        .POSITION_BITS(POS_W)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .results_seen   (results_seen),
        .fail_count     (fail_count),
        .stopped_seen   (stopped_seen),
        .starts_seen    (starts_seen),
        .saturated_seen (saturated_seen)
    );

    // receiver: always ready, random short stalls, or rare long stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 400);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (ready_mode == 1)
        begin
            m_tready <= ($urandom_range(0, 9) > 2);
        end
        else if (ready_mode == 2 && $urandom_range(0, 15) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(5, 40);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d of %0d results in",
                         IDLE_LIMIT, results_seen, words_sent);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input int tgt, input int meas);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 80)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 2 * POS_W){1'b0}}, POS_W'(meas), POS_W'(tgt)};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        burst_left--;
    endtask

    task automatic put_reg(input logic [pidsr_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[pidsr_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    // only called with the core idle: the previous set has fully drained
    task automatic load_config(input int unsigned kp, input int unsigned ki,
                               input int unsigned kd, input int unsigned band,
                               input int unsigned win, input int unsigned lim,
                               input int unsigned pmin, input int unsigned pmax);
        s_tvalid <= 1'b0;
        while (results_seen != words_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
        put_reg(pidsr_pkg::REG_KP, kp);
        put_reg(pidsr_pkg::REG_KI, ki);
        put_reg(pidsr_pkg::REG_KD, kd);
        put_reg(pidsr_pkg::REG_DEADBAND, band);
        put_reg(pidsr_pkg::REG_WINDOW, win);
        put_reg(pidsr_pkg::REG_LIMIT, lim);
        put_reg(pidsr_pkg::REG_PSC_MIN, pmin);
        put_reg(pidsr_pkg::REG_PSC_MAX, pmax);
        cfg_write    <= 1'b0;
        cur_deadband = band;
        burst_left   = 0;
    endtask

    function automatic int clip_pos(input int v);
        return (v < 0) ? 0 : ((v > POS_TOP) ? POS_TOP : v);
    endfunction

    // mostly tracking runs where the measured position closes in on a held
    // target, mixed with errors around the deadband, extremes and noise
    task automatic send_random(input int count);
        int tgt, meas, e, pick, track_left, hold_tgt;
        track_left = 0;
        hold_tgt   = 0;
        meas       = $urandom_range(0, POS_TOP);
        for (int i = 0; i < count; i++)
        begin
            if (track_left > 0)
            begin
                tgt  = hold_tgt;
                meas = clip_pos(meas + ((tgt - meas) * int'($urandom_range(1, 6))) / 8
                                + int'($urandom_range(0, 6)) - 3);
                track_left--;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                meas = $urandom_range(0, POS_TOP);
                e    = 0;
                case (pick)
                    0, 1, 2:
                    begin
                        hold_tgt   = $urandom_range(0, POS_TOP);
                        track_left = $urandom_range(5, 30);
                        e          = hold_tgt - meas;
                    end
                    3, 4: e = $urandom_range(0, 300) - 150;
                    5:    e = (cur_deadband + $urandom_range(0, 4) - 2)
                              * (($urandom_range(0, 1) == 1) ? 1 : -1);
                    6:    e = 0;
                    7:
                    begin
                        meas = ($urandom_range(0, 1) == 1) ? POS_TOP : 0;
                        e    = (($urandom_range(0, 1) == 1) ? POS_TOP : 0) - meas;
                    end
                    default: e = int'($urandom_range(0, POS_TOP)) - meas;
                endcase
                tgt = meas + e;
                if (tgt < 0 || tgt > POS_TOP)
                    tgt = clip_pos(meas - e);
            end
            send_word(tgt, meas);
        end
    endtask

    task automatic load_random_config();
        int unsigned pmin, pmax;
        pmin = $urandom_range(0, 16'hFFFF) >> $urandom_range(0, 10);
        pmax = $urandom_range(0, 16'hFFFF) >> $urandom_range(0, 6);
        load_config($urandom_range(0, 24'hFFFFFF) >> $urandom_range(4, 20),
                    $urandom_range(0, 24'hFFFFFF) >> $urandom_range(6, 23),
                    $urandom_range(0, 24'hFFFFFF) >> $urandom_range(4, 20),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 200)
                                                : $urandom_range(0, 12),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    pmin, pmax);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: deadband edges, both signs, full scale, integral clamp
        send_word(0, 0);
        send_word(5, 0);
        send_word(0, 5);
        send_word(6, 0);
        send_word(7, 0);
        send_word(0, 6);
        send_word(POS_TOP, 0);
        send_word(0, POS_TOP);
        send_word(POS_TOP, POS_TOP);
        send_word(512, 512);
        send_word(612, 512);
        send_word(611, 512);
        repeat (5) send_word(562, 512);
        repeat (5) send_word(462, 512);
        send_word(0, 0);
        send_word(10, 0);
        send_random(WORDS_PER_SET);

        for (int phase = 1; phase < N_PHASES; phase++)
        begin
            case (phase)
                // full gains saturate the output
                1: load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1023, 1023, 1, 16'hFFFF);
                // everything zero
                2: load_config(0, 0, 0, 0, 0, 0, 0, 0);
                // every register at its top: the deadband swallows all errors
                3: load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1023, 1023, 1023,
                               16'hFFFF, 16'hFFFF);
                // fast prescaler above the slow one
                4: load_config(150000, 2000, 60000, 3, 200, 500, 5000, 200);
                default: load_random_config();
            endcase
            send_random((phase == 3) ? 20 : WORDS_PER_SET);
        end

        s_tvalid <= 1'b0;
        while (results_seen != words_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d position words over %0d gain settings, %0d results checked",
                 words_sent, N_PHASES, results_seen);
        $display("%0d stopped in the deadband, %0d drive starts, %0d saturated pid values",
                 stopped_seen, starts_seen, saturated_seen);
        if (fail_count == 0 && results_seen == words_sent)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/pidsr_pkg.sv
design/pid_position_to_step_rate_core.sv
verif/pidsr_step_checker.sv
verif/pid_position_to_step_rate_core_test.sv
